/* rtl/mdfe_pkg.sv */
// Package for the motor duty frame encoder: types, frame constants and CRC step.
// No dependencies; imported by every module of the block.
`default_nettype none

package mdfe_pkg;

    localparam int DUTY_W  = 17;
    localparam int SPEED_W = 7;
    localparam int PROD_W  = 24;
    localparam int RECIP_W = 25;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam int RECIP_SH = 31;
    localparam int CNT_W   = 3;
    localparam int PTR_W   = 2;
    localparam int IDX_W   = 4;

    localparam logic [DUTY_W-1:0]  FULL_SCALE = 17'd100000;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;
    // ceil(2^31 / 100): exact floor(p / 100) for p below 2^24
    localparam logic [RECIP_W-1:0] RECIP_100  = 25'd21474837;

    localparam logic [CNT_W-1:0] Q_DEPTH = 3'd4;

    localparam logic [0:0] REG_MAX_DUTY = 1'b0;
    localparam logic [0:0] REG_OUT_EN   = 1'b1;

    localparam logic [IDX_W-1:0] IDX_START = 4'd0;
    localparam logic [IDX_W-1:0] IDX_LEN   = 4'd1;
    localparam logic [IDX_W-1:0] IDX_CMD   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_D3    = 4'd3;
    localparam logic [IDX_W-1:0] IDX_D2    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_D1    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_D0    = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CRC_H = 4'd7;
    localparam logic [IDX_W-1:0] IDX_CRC_L = 4'd8;
    localparam logic [IDX_W-1:0] IDX_STOP  = 4'd9;

    localparam logic [7:0] BYTE_START = 8'h02;
    localparam logic [7:0] BYTE_LEN   = 8'h05;
    localparam logic [7:0] BYTE_CMD   = 8'h05;
    localparam logic [7:0] BYTE_STOP  = 8'h03;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic              empty;
        logic [CNT_W-1:0]  count;
        logic [DUTY_W-1:0] head;
    } t_q_stat;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/motor_duty_frame_encoder.sv */
// Motor duty frame encoder top level: front end, duty queue and frame sequencer.
// Depends on mdfe_pkg, mdfe_front, mdfe_fifo and mdfe_back.
//
// Input channel: drive i_motor_speed and raise push; the command is taken at
// an edge where full is low. Output channel: while empty is low, o_frame_byte
// and o_last_byte hold the oldest byte; raise pop to take it.
// Each enabled command becomes a ten-byte frame (start, length, command, four
// big-endian duty bytes, CRC-16 high then low, stop); o_last_byte marks the
// stop byte. With outputs disabled a command is taken and dropped.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 max duty, 1 output enable) at the clock edge; the user must write only
// while the block is idle; the block itself does not enforce it. A command's
// first byte passes the two multiply stages, the queue and the output register.
// Throughput: one byte per cycle while bytes are taken, as the sequencer emits
// a single byte per cycle. The front end holds a two-stage multiply pipeline
// and a four-entry queue, so commands are taken back to back until queued and
// in-flight commands fill it. Reset (synchronous, active low) empties the
// pipeline and queue, sets max duty to full scale and disables outputs. On a
// receiver stall the output byte holds, the sequencer waits and full rises.
`default_nettype none

module motor_duty_frame_encoder import mdfe_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        i_motor_speed,
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             o_frame_byte,
    output logic                   o_last_byte,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_idx,
    input  wire logic [DUTY_W-1:0] i_cfg_wdata
);

    t_q_stat           q_stat;
    logic              q_push;
    logic [DUTY_W-1:0] q_data;
    logic              q_pop;

    mdfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_motor_speed(i_motor_speed),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_stat     (q_stat),
        .o_q_push     (q_push),
        .o_q_data     (q_data)
    );

    mdfe_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_data),
        .i_pop  (q_pop),
        .o_stat (q_stat)
    );

    mdfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .o_q_pop     (q_pop),
        .o_frame_byte(o_frame_byte),
        .o_last_byte (o_last_byte),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

`default_nettype wire

/* rtl/mdfe_front.sv */
// Front end: configuration registers, speed clamp and duty scaling pipeline.
// Depends on mdfe_pkg; feeds duty values into mdfe_fifo.
`default_nettype none

module mdfe_front import mdfe_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        i_motor_speed,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_idx,
    input  wire logic [DUTY_W-1:0] i_cfg_wdata,
    input  wire t_q_stat           i_q_stat,
    output logic                   o_q_push,
    output logic [DUTY_W-1:0]      o_q_data
);

    logic [DUTY_W-1:0] r_max_duty;
    logic              r_out_en;
    logic              r_v1;
    logic              r_v2;
    logic [PROD_W-1:0] r_prod;
    logic [MUL_W-1:0]  r_mul;

    logic [SPEED_W-1:0] speed;
    logic [DUTY_W-1:0]  md;
    logic [CNT_W-1:0]   in_flight;
    logic               accept;

    always_comb begin
        if (i_motor_speed[7]) begin
            speed = '0;
        end else if (i_motor_speed[6:0] > SPEED_MAX) begin
            speed = SPEED_MAX;
        end else begin
            speed = i_motor_speed[6:0];
        end
        md = (r_max_duty > FULL_SCALE) ? FULL_SCALE : r_max_duty;
    end

    assign in_flight = i_q_stat.count + {{(CNT_W-1){1'b0}}, r_v1}
                                      + {{(CNT_W-1){1'b0}}, r_v2};
    assign full      = (in_flight >= Q_DEPTH);
    assign accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty <= FULL_SCALE;
            r_out_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_DUTY: r_max_duty <= i_cfg_wdata;
                REG_OUT_EN:   r_out_en   <= i_cfg_wdata[0];
                default:      r_out_en   <= r_out_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept && r_out_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {{(PROD_W-DUTY_W){1'b0}}, md} * {{(PROD_W-SPEED_W){1'b0}}, speed};
        r_mul  <= {{(MUL_W-PROD_W){1'b0}}, r_prod} * {{(MUL_W-RECIP_W){1'b0}}, RECIP_100};
    end

    assign o_q_push = r_v2;
    assign o_q_data = r_mul[RECIP_SH +: DUTY_W];

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_flight <= Q_DEPTH)
        else $error("front: queue credit overrun");

endmodule

`default_nettype wire

/* rtl/mdfe_fifo.sv */
// Short queue of duty values between the front end and the frame sequencer.
// Depends on mdfe_pkg.
`default_nettype none

module mdfe_fifo import mdfe_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DUTY_W-1:0] i_data,
    input  wire logic              i_pop,
    output t_q_stat                o_stat
);

    logic [DUTY_W-1:0] r_mem [2**PTR_W];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;
    assign o_stat.head  = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count < Q_DEPTH)
        else $error("fifo: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("fifo: pop while empty");

endmodule

`default_nettype wire

/* rtl/mdfe_back.sv */
// Frame sequencer: emits the ten frame bytes of each duty value, CRC byte by byte.
// Depends on mdfe_pkg; drains mdfe_fifo.
`default_nettype none

module mdfe_back import mdfe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_q_stat i_q_stat,
    output logic        o_q_pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    output logic        empty,
    input  wire logic   pop
);

    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    logic [DUTY_W-1:0] r_duty;
    logic [15:0]       r_crc;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic        adv;
    logic        load;
    logic [31:0] duty_word;
    logic [7:0]  cur_byte;

    assign adv       = !r_out_valid || pop;
    assign load      = (!r_busy || (adv && r_idx == IDX_STOP)) && !i_q_stat.empty;
    assign duty_word = {{(32-DUTY_W){1'b0}}, r_duty};

    always_comb begin
        case (r_idx)
            IDX_START: cur_byte = BYTE_START;
            IDX_LEN:   cur_byte = BYTE_LEN;
            IDX_CMD:   cur_byte = BYTE_CMD;
            IDX_D3:    cur_byte = duty_word[31:24];
            IDX_D2:    cur_byte = duty_word[23:16];
            IDX_D1:    cur_byte = duty_word[15:8];
            IDX_D0:    cur_byte = duty_word[7:0];
            IDX_CRC_H: cur_byte = r_crc[15:8];
            IDX_CRC_L: cur_byte = r_crc[7:0];
            IDX_STOP:  cur_byte = BYTE_STOP;
            default:   cur_byte = BYTE_STOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= IDX_START;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= IDX_START;
            end else if (adv && r_busy) begin
                if (r_idx == IDX_STOP) begin
                    r_busy <= 1'b0;
                    r_idx  <= IDX_START;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= cur_byte;
            r_out_last <= (r_idx == IDX_STOP);
        end
        if (load) begin
            r_duty <= i_q_stat.head;
            r_crc  <= '0;
        end else if (adv && r_busy && (r_idx inside {[IDX_CMD:IDX_D0]})) begin
            r_crc <= crc16_byte(r_crc, cur_byte);
        end
    end

    assign o_q_pop      = load;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;
    assign empty        = !r_out_valid;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_STOP)
        else $error("back: byte index out of range");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_busy && r_idx == IDX_STOP) |=> (r_out_valid && r_out_last))
        else $error("back: stop byte not marked last");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == IDX_START)
        else $error("back: idle with index not at start");

endmodule

`default_nettype wire
